[design/cpab_pkg.sv]
`timescale 1ns / 1ps

package cpab_pkg;

  // Largest frame the address logic serves
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int REG_W   = 12;
  localparam int IDX_W   = 3;
  localparam int COORD_W = 16;
  localparam int PIX_W   = 32;
  localparam int CH_W    = 8;
  localparam int ADDR_W  = 22;
  // Clip edges are compared at this width so the frame limits always fit
  localparam int EDGE_W  = 16;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 56;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_CLIP_LEFT    = 3'd0;
  localparam logic [IDX_W-1:0] REG_CLIP_TOP     = 3'd1;
  localparam logic [IDX_W-1:0] REG_CLIP_RIGHT   = 3'd2;
  localparam logic [IDX_W-1:0] REG_CLIP_BOTTOM  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH = 3'd4;

  localparam logic [REG_W-1:0] RST_CLIP_LEFT    = 12'd0;
  localparam logic [REG_W-1:0] RST_CLIP_TOP     = 12'd0;
  localparam logic [REG_W-1:0] RST_CLIP_RIGHT   = 12'd1024;
  localparam logic [REG_W-1:0] RST_CLIP_BOTTOM  = 12'd768;
  localparam logic [REG_W-1:0] RST_SCREEN_WIDTH = 12'd1024;

  localparam logic ACT_PUT   = 1'b0;
  localparam logic ACT_BLEND = 1'b1;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

  typedef struct packed {
    logic [REG_W-1:0] clip_left;
    logic [REG_W-1:0] clip_top;
    logic [REG_W-1:0] clip_right;
    logic [REG_W-1:0] clip_bottom;
    logic [REG_W-1:0] screen_width;
  } cfg_t;

  typedef struct packed {
    logic                      action;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [PIX_W-1:0]          src_color;
    logic [PIX_W-1:0]          dst_color;
  } req_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] pixel_address;
    logic [PIX_W-1:0]  pixel_value;
  } res_t;

endpackage

[design/cpab_cfg.sv]
`timescale 1ns / 1ps

module cpab_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [cpab_pkg::IDX_W-1:0] cfg_index,
  input  logic [cpab_pkg::REG_W-1:0] cfg_data,
  output cpab_pkg::cfg_t            cfg
);
  import cpab_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clip_left    <= RST_CLIP_LEFT;
      cfg.clip_top     <= RST_CLIP_TOP;
      cfg.clip_right   <= RST_CLIP_RIGHT;
      cfg.clip_bottom  <= RST_CLIP_BOTTOM;
      cfg.screen_width <= RST_SCREEN_WIDTH;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CLIP_LEFT:    cfg.clip_left    <= cfg_data;
        REG_CLIP_TOP:     cfg.clip_top     <= cfg_data;
        REG_CLIP_RIGHT:   cfg.clip_right   <= cfg_data;
        REG_CLIP_BOTTOM:  cfg.clip_bottom  <= cfg_data;
        REG_SCREEN_WIDTH: cfg.screen_width <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[design/cpab_clip.sv]
`timescale 1ns / 1ps

module cpab_clip (
  input  cpab_pkg::cfg_t                   cfg,
  input  logic signed [cpab_pkg::COORD_W-1:0] pos_x,
  input  logic signed [cpab_pkg::COORD_W-1:0] pos_y,
  output logic                             in_clip,
  output logic [cpab_pkg::ADDR_W-1:0]      addr
);
  import cpab_pkg::*;

  localparam logic [EDGE_W-1:0] MAX_W = EDGE_W'(MAX_WIDTH);
  localparam logic [EDGE_W-1:0] MAX_H = EDGE_W'(MAX_HEIGHT);
  localparam int PROD_W = 2 * REG_W;

  logic [EDGE_W-1:0] right;
  logic [EDGE_W-1:0] bottom;
  logic [EDGE_W-1:0] sw;
  logic [EDGE_W-1:0] ux;
  logic [EDGE_W-1:0] uy;
  logic [PROD_W-1:0] lin;

  always_comb begin
    sw     = EDGE_W'(cfg.screen_width);
    right  = EDGE_W'(cfg.clip_right);
    bottom = EDGE_W'(cfg.clip_bottom);
    if (right > sw)    right  = sw;
    if (right > MAX_W) right  = MAX_W;
    if (bottom > MAX_H) bottom = MAX_H;

    ux = {1'b0, pos_x[COORD_W-2:0]};
    uy = {1'b0, pos_y[COORD_W-2:0]};

    in_clip = !pos_x[COORD_W-1] && !pos_y[COORD_W-1] &&
              (ux >= EDGE_W'(cfg.clip_left)) && (ux < right) &&
              (uy >= EDGE_W'(cfg.clip_top))  && (uy < bottom);

    // Inside the rectangle both coordinates are below 4096, so the low
    // register-width bits carry the whole value.
    lin  = PROD_W'(pos_y[REG_W-1:0]) * PROD_W'(cfg.screen_width)
         + PROD_W'(pos_x[REG_W-1:0]);
    addr = lin[ADDR_W-1:0];
  end

endmodule

[design/cpab_mix.sv]
`timescale 1ns / 1ps

module cpab_mix (
  input  logic                       action,
  input  logic [cpab_pkg::PIX_W-1:0] src_color,
  input  logic [cpab_pkg::PIX_W-1:0] dst_color,
  output logic                       paint,
  output logic [cpab_pkg::PIX_W-1:0] color
);
  import cpab_pkg::*;

  localparam int NCH    = 3;
  localparam int SUM_W  = 2 * CH_W;

  // floor(v / 255) for v below 65280
  function automatic logic [CH_W-1:0] div255(input logic [SUM_W-1:0] v);
    logic [SUM_W:0] t;
    t = {1'b0, v} + (SUM_W+1)'(v[SUM_W-1:CH_W]) + (SUM_W+1)'(1);
    return t[SUM_W-1:CH_W];
  endfunction

  logic [CH_W-1:0]  alpha;
  logic [CH_W-1:0]  inv;
  logic [SUM_W-1:0] acc   [NCH];
  logic [CH_W-1:0]  mixed [NCH];

  always_comb begin
    alpha = src_color[PIX_W-1 -: CH_W];
    inv   = ALPHA_OPAQUE - alpha;
    for (int c = 0; c < NCH; c++) begin
      acc[c] = SUM_W'(src_color[c*CH_W +: CH_W]) * SUM_W'(alpha)
             + SUM_W'(dst_color[c*CH_W +: CH_W]) * SUM_W'(inv);
      mixed[c] = div255(acc[c]);
    end

    if (action == ACT_PUT || alpha == ALPHA_OPAQUE) begin
      paint = 1'b1;
      color = {ALPHA_OPAQUE, src_color[PIX_W-CH_W-1:0]};
    end else begin
      paint = (alpha != ALPHA_CLEAR);
      color = {ALPHA_OPAQUE, mixed[2], mixed[1], mixed[0]};
    end
  end

endmodule

[design/clipped_pixel_alpha_blend.sv]
`timescale 1ns / 1ps

// Clipped ARGB8888 pixel writer with alpha blending. Each input transfer is
// one pixel request; each output transfer is one result: a write flag, the
// linear address y*screen_width+x (22 bits, wrapping) and the opaque pixel.
// Pixels outside the clip rectangle, and blends with zero alpha, come out
// with the flag low and address and value zero. One pixel per clock is
// taken unless the result side stalls: one input register, then clip test,
// address multiply and the three channel blends in a single stage, then the
// result register. Both sides may stall freely. The user must write the
// registers through cfg_write/cfg_index/cfg_data only while no pixel is in
// flight (not enforced here); reset clip 0..1024 by 0..768, stride 1024.
module clipped_pixel_alpha_blend (
  input  logic                            clk,
  input  logic                            rst,

  input  logic                            cfg_write,
  input  logic [cpab_pkg::IDX_W-1:0]      cfg_index,
  input  logic [cpab_pkg::REG_W-1:0]      cfg_data,

  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x [15:0], pos_y [31:16], src_color [63:32], dst_color [95:64]
  input  logic [cpab_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  logic                            s_axis_tuser,

  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pixel_address [21:0], pixel_value [53:22], zero pad [55:54]
  output logic [cpab_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // write_enable
  output logic                            m_axis_tuser
);
  import cpab_pkg::*;

  localparam int PAD_W = OUT_DATA_W - ADDR_W - PIX_W;

  cfg_t cfg;
  logic req_valid;
  req_t req;
  logic out_valid;
  res_t res;
  res_t res_next;
  logic advance;
  logic in_clip;
  logic [ADDR_W-1:0] addr;
  logic paint;
  logic [PIX_W-1:0] color;

  cpab_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cpab_clip u_clip (
    .cfg     (cfg),
    .pos_x   (req.pos_x),
    .pos_y   (req.pos_y),
    .in_clip (in_clip),
    .addr    (addr)
  );

  cpab_mix u_mix (
    .action    (req.action),
    .src_color (req.src_color),
    .dst_color (req.dst_color),
    .paint     (paint),
    .color     (color)
  );

  always_comb begin
    res_next.write_enable  = in_clip && paint;
    res_next.pixel_address = res_next.write_enable ? addr : '0;
    res_next.pixel_value   = res_next.write_enable ? color : '0;
  end

  // Result register frees when empty or taken; input register frees when
  // empty or when its pixel moves on.
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) req_valid <= s_axis_tvalid;
      if (advance) out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req.action    <= s_axis_tuser;
      req.pos_x     <= s_axis_tdata[15:0];
      req.pos_y     <= s_axis_tdata[31:16];
      req.src_color <= s_axis_tdata[63:32];
      req.dst_color <= s_axis_tdata[95:64];
    end
    if (advance && req_valid) res <= res_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = res.write_enable;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, res.pixel_value, res.pixel_address};

  // A dropped pixel carries zero address and value
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("dropped pixel with nonzero payload");

  // Every written pixel is opaque
  a_opaque: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[53:46] == ALPHA_OPAQUE)
    else $error("written pixel not opaque");

  // A pixel in the input register reaches an empty result register next cycle
  a_forward: assert property (@(posedge clk) disable iff (rst)
    req_valid && !out_valid |=> out_valid)
    else $error("pixel not forwarded to result register");

endmodule

[tb/pixel_blend_checker.sv]
`timescale 1ns / 1ps

module pixel_blend_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [cpab_pkg::IDX_W-1:0]      cfg_index,
  input  logic [cpab_pkg::REG_W-1:0]      cfg_data,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // pos_x [15:0], pos_y [31:16], src_color [63:32], dst_color [95:64]
  input  logic [cpab_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  logic                            s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pixel_address [21:0], pixel_value [53:22], zero pad [55:54]
  input  logic [cpab_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // write_enable
  input  logic                            m_axis_tuser,
  output int                              fail_count,
  output int                              pixels_pending
);
  import cpab_pkg::*;

  cfg_t clip_cfg;
  res_t expected_pixels[$];

  function automatic logic [CH_W-1:0] blend_channel(int s, int d, int a);
    int mixed;
    mixed = (s * a + d * (255 - a)) / 255;
    return mixed[CH_W-1:0];
  endfunction

  function automatic res_t predict_pixel(logic act, logic signed [COORD_W-1:0] px,
                                         logic signed [COORD_W-1:0] py,
                                         logic [PIX_W-1:0] src, logic [PIX_W-1:0] dst);
    res_t r;
    int xi, yi, left, top, right, bottom, stride, lin;
    logic [CH_W-1:0] a;
    r = '0;
    xi = int'(px);
    yi = int'(py);
    left = int'(clip_cfg.clip_left);
    top = int'(clip_cfg.clip_top);
    stride = int'(clip_cfg.screen_width);
    right = int'(clip_cfg.clip_right);
    bottom = int'(clip_cfg.clip_bottom);
    if (right > stride) right = stride;
    if (right > MAX_WIDTH) right = MAX_WIDTH;
    if (bottom > MAX_HEIGHT) bottom = MAX_HEIGHT;
    if (xi >= 0 && yi >= 0 && xi >= left && xi < right && yi >= top && yi < bottom) begin
      a = src[31:24];
      if (act == ACT_PUT || a == ALPHA_OPAQUE) begin
        r.write_enable = 1'b1;
        r.pixel_value = src | {ALPHA_OPAQUE, 24'h0};
      end else if (a != ALPHA_CLEAR) begin
        r.write_enable = 1'b1;
        r.pixel_value = {ALPHA_OPAQUE,
                         blend_channel(int'(src[23:16]), int'(dst[23:16]), int'(a)),
                         blend_channel(int'(src[15:8]), int'(dst[15:8]), int'(a)),
                         blend_channel(int'(src[7:0]), int'(dst[7:0]), int'(a))};
      end
      if (r.write_enable) begin
        lin = yi * stride + xi;
        r.pixel_address = lin[ADDR_W-1:0];
      end
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pixels_pending = 0;
  end

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) begin
      clip_cfg.clip_left = RST_CLIP_LEFT;
      clip_cfg.clip_top = RST_CLIP_TOP;
      clip_cfg.clip_right = RST_CLIP_RIGHT;
      clip_cfg.clip_bottom = RST_CLIP_BOTTOM;
      clip_cfg.screen_width = RST_SCREEN_WIDTH;
      expected_pixels.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CLIP_LEFT:    clip_cfg.clip_left = cfg_data;
          REG_CLIP_TOP:     clip_cfg.clip_top = cfg_data;
          REG_CLIP_RIGHT:   clip_cfg.clip_right = cfg_data;
          REG_CLIP_BOTTOM:  clip_cfg.clip_bottom = cfg_data;
          REG_SCREEN_WIDTH: clip_cfg.screen_width = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_pixels.push_back(predict_pixel(s_axis_tuser, s_axis_tdata[15:0],
                                                s_axis_tdata[31:16], s_axis_tdata[63:32],
                                                s_axis_tdata[95:64]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.write_enable = m_axis_tuser;
        got.pixel_address = m_axis_tdata[21:0];
        got.pixel_value = m_axis_tdata[53:22];
        if (m_axis_tdata[55:54] != 2'b00) begin
          $error("pad: expected 0 got %0h", m_axis_tdata[55:54]);
          fail_count++;
        end
        if (expected_pixels.size() == 0) begin
          $error("output transfer with no pixel pending");
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.write_enable !== want.write_enable) begin
            $error("write_enable: expected %0b got %0b", want.write_enable, got.write_enable);
            fail_count++;
          end
          if (got.pixel_address !== want.pixel_address) begin
            $error("pixel_address: expected %0h got %0h",
                   want.pixel_address, got.pixel_address);
            fail_count++;
          end
          if (got.pixel_value !== want.pixel_value) begin
            $error("pixel_value: expected %08h got %08h", want.pixel_value, got.pixel_value);
            fail_count++;
          end
        end
      end
    end
    pixels_pending = expected_pixels.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import cpab_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 135;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [IDX_W-1:0]      cfg_index;
  logic [REG_W-1:0]      cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  int fail_count;
  int pixels_pending;
  int idle_cycles;
  logic steady_flow;
  logic hold_off_req;
  logic hold_off_done;
  int cur_left, cur_top, cur_right, cur_bottom, cur_width;

  clipped_pixel_alpha_blend uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  pixel_blend_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .fail_count(fail_count), .pixels_pending(pixels_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall watchdog: no transfer on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Result side backpressure, with one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_off_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end else begin
        m_axis_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 25);
        @(negedge clk);
      end
    end
  end

  task automatic write_clip(int l, int t, int r, int b, int w);
    cfg_write <= 1'b1;
    cfg_index <= REG_CLIP_LEFT;
    cfg_data <= l[REG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_CLIP_TOP;
    cfg_data <= t[REG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_CLIP_RIGHT;
    cfg_data <= r[REG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_CLIP_BOTTOM;
    cfg_data <= b[REG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data <= w[REG_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_left = l;
    cur_top = t;
    cur_right = r;
    cur_bottom = b;
    cur_width = w;
  endtask

  // Caller is at a falling edge; returns at the falling edge after the transfer
  task automatic send_pixel(logic act, logic [15:0] px, logic [15:0] py,
                            logic [31:0] src, logic [31:0] dst);
    while (!steady_flow && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {dst, src, py, px};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_pixels();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pixels_pending != 0) @(negedge clk);
  endtask

  // Mostly near the clip window and its edges, sometimes anywhere in 16 bits
  function automatic logic [15:0] pick_coord(int lo, int hi);
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 10)
      v = $urandom_range(65535);
    else if (r < 25)
      case ($urandom_range(3))
        0: v = lo - 1;
        1: v = lo;
        2: v = hi - 1;
        default: v = hi;
      endcase
    else if (r < 35)
      v = $urandom_range(4095);
    else if (hi > lo)
      v = $urandom_range(hi - 1, lo);
    else
      v = lo + $urandom_range(3);
    return v[15:0];
  endfunction

  task automatic send_random_pixel();
    int r;
    int eff_right;
    int eff_bottom;
    logic [7:0] a;
    logic [31:0] src;
    eff_right = cur_right;
    if (eff_right > cur_width) eff_right = cur_width;
    if (eff_right > MAX_WIDTH) eff_right = MAX_WIDTH;
    eff_bottom = (cur_bottom > MAX_HEIGHT) ? MAX_HEIGHT : cur_bottom;
    r = $urandom_range(99);
    if (r < 15) a = ALPHA_CLEAR;
    else if (r < 30) a = ALPHA_OPAQUE;
    else if (r < 38) a = 8'd1;
    else if (r < 45) a = 8'd254;
    else a = 8'($urandom_range(255));
    src = $urandom;
    src[31:24] = a;
    send_pixel(1'($urandom_range(1)), pick_coord(cur_left, eff_right),
               pick_coord(cur_top, eff_bottom), src, $urandom);
  endtask

  initial begin
    int l, t, r, b, w;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_PUT;
    steady_flow = 1'b0;
    hold_off_req = 1'b0;
    cur_left = int'(RST_CLIP_LEFT);
    cur_top = int'(RST_CLIP_TOP);
    cur_right = int'(RST_CLIP_RIGHT);
    cur_bottom = int'(RST_CLIP_BOTTOM);
    cur_width = int'(RST_SCREEN_WIDTH);
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, on the reset clip window
    send_pixel(ACT_PUT, 16'd0, 16'd0, 32'h00123456, 32'hDEADBEEF);
    send_pixel(ACT_PUT, 16'd1023, 16'd767, 32'h7FABCDEF, 32'h00000000);
    send_pixel(ACT_PUT, 16'd1024, 16'd0, 32'hFF112233, 32'h00000000);
    send_pixel(ACT_PUT, 16'd0, 16'd768, 32'hFF112233, 32'h00000000);
    send_pixel(ACT_PUT, 16'hFFFF, 16'd0, 32'hFF445566, 32'h00000000);
    send_pixel(ACT_PUT, 16'd0, 16'hFFFF, 32'hFF445566, 32'h00000000);
    send_pixel(ACT_PUT, 16'h8000, 16'h7FFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_pixel(ACT_PUT, 16'h7FFF, 16'h8000, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_pixel(ACT_PUT, 16'd1, 16'd1, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_pixel(ACT_PUT, 16'd2, 16'd3, 32'h00000000, 32'h00000000);
    send_pixel(ACT_BLEND, 16'd5, 16'd5, 32'h00FFFFFF, 32'h12345678);
    send_pixel(ACT_BLEND, 16'd1023, 16'd0, 32'hFF000000, 32'hFFFFFFFF);
    send_pixel(ACT_BLEND, 16'd0, 16'd767, 32'hFFFFFFFF, 32'h00000000);
    send_pixel(ACT_BLEND, 16'd100, 16'd200, 32'h01FFFFFF, 32'h00000000);
    send_pixel(ACT_BLEND, 16'd100, 16'd201, 32'hFE000000, 32'h00FFFFFF);
    send_pixel(ACT_BLEND, 16'd512, 16'd384, 32'h80FF8000, 32'hFF0080FF);
    send_pixel(ACT_BLEND, 16'd1024, 16'd767, 32'h80FFFFFF, 32'h00000000);
    send_pixel(ACT_BLEND, 16'hFFFF, 16'hFFFF, 32'h80FFFFFF, 32'h00000000);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_pixels();
      // let the pipeline settle before touching the registers
      repeat (4) @(negedge clk);
      case (ph)
        0: write_clip(0, 0, MAX_WIDTH, MAX_HEIGHT, MAX_WIDTH);
        1: write_clip(0, 0, 4095, 4095, 4095);              // stride wraps the address
        3: write_clip(500, 0, 500, MAX_HEIGHT, MAX_WIDTH);  // empty window
        4: write_clip(0, 0, MAX_WIDTH, MAX_HEIGHT, 0);      // zero width drops all
        5: write_clip(2047, 2047, MAX_WIDTH, MAX_HEIGHT, MAX_WIDTH);
        6: write_clip(0, 0, MAX_WIDTH, MAX_HEIGHT, 1);
        default: begin
          l = $urandom_range(2100);
          t = $urandom_range(2100);
          r = l + $urandom_range(400, 1);
          b = t + $urandom_range(400, 1);
          w = ($urandom_range(1) == 0) ? MAX_WIDTH : $urandom_range(MAX_WIDTH, 1);
          if (r > 4095) r = 4095;
          if (b > 4095) b = 4095;
          write_clip(l, t, r, b, w);
        end
      endcase
      steady_flow = (ph == 7);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 8 && i == 30) hold_off_req = 1'b1;
        send_random_pixel();
      end
    end
    steady_flow = 1'b0;

    drain_pixels();
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
design/cpab_pkg.sv
design/cpab_cfg.sv
design/cpab_clip.sv
design/cpab_mix.sv
design/clipped_pixel_alpha_blend.sv
tb/pixel_blend_checker.sv
tb/testbench.sv
